@@ hw/rtl/swsb_pkg.sv @@
// Shared types, constants and codes for the sliding window source ban unit.
`default_nettype none

package swsb_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int WINDOW_DEPTH_DEF  = 1024;
    localparam int BAN_ENTRIES_DEF   = 64;

    localparam int ADDR_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 3;
    localparam int EXP_W    = 11;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd10;
    localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd60;
    localparam logic [CFG_W-1:0] BAN_RST       = 16'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAN       = 2'd2;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BANNED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TFULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WFULL   = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
        logic               dropped;
    } win_entry_t;

    // Operands of the shared add and compare unit.
    typedef struct packed {
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] b;
        logic [STAMP_W-1:0] c;
    } alu_op_t;

    typedef struct packed {
        logic [STAMP_W-1:0] sum_sat;
        logic               ge;
    } alu_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/sliding_window_source_ban_unit.sv @@
// Top level: sequencer, counter, ban and window stores of the source ban unit.
//
//   channel   direction  signals                               handshake
//   input     in         cmd, source_addr, stamp               in_valid / in_ready
//   result    out        status, source_count, expired         out_valid / out_ready
//   config    in         cfg_index, cfg_data                   cfg_we
//
// One item at a time. An access scans the ban table, stopping on a hit, then the counter
// table, stopping on a match, with a read and a check per entry, then updates the stores.
// A tick retires expired window entries; a counted one first scans the counter table to
// decrement its source. The single-port stores and their registered reads set this pace.
// Reset clears valid bits, pointers and time; the next item may be accepted while a
// result still waits in the output register, and a finished item holds until it leaves.
`default_nettype none

module sliding_window_source_ban_unit
    import swsb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
    parameter int BAN_ENTRIES   = BAN_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cmd,
    input  wire logic [ADDR_W-1:0]    source_addr,
    input  wire logic [STAMP_W-1:0]   stamp,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [CNT_W-1:0]          source_count,
    output logic [EXP_W-1:0]          expired,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CIW = $clog2(TABLE_ENTRIES);
    localparam int BIW = $clog2(BAN_ENTRIES);
    localparam int WIW = $clog2(WINDOW_DEPTH);
    localparam int PW  = $clog2(2 * WINDOW_DEPTH);

    localparam logic [CIW-1:0] C_LAST = CIW'(TABLE_ENTRIES - 1);
    localparam logic [BIW-1:0] B_LAST = BIW'(BAN_ENTRIES - 1);
    localparam logic [PW-1:0]  P_TOP  = PW'(2 * WINDOW_DEPTH - 1);
    localparam logic [PW-1:0]  P_DEPTH = PW'(WINDOW_DEPTH);
    localparam logic [PW:0]    P_SPAN = (PW+1)'(2 * WINDOW_DEPTH);
    localparam logic [PW:0]    P_FULL = (PW+1)'(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_BAN_RD, S_BAN_CHK, S_CNT_RD, S_CNT_CHK, S_UPDATE, S_BAN_WR,
        S_TICK_RD, S_TICK_CHK, S_EXP_RD, S_EXP_CHK, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [STAMP_W-1:0]  cur_reg, cur_next;
    logic [PW-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [BIW-1:0]      bidx_reg, bidx_next;
    logic [CIW-1:0]      cidx_reg, cidx_next;
    logic                bfree_reg, bfree_next;
    logic [BIW-1:0]      bfree_idx_reg, bfree_idx_next;
    logic [BIW-1:0]      old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0]  old_val_reg, old_val_next;
    logic                cfree_reg, cfree_next;
    logic [CIW-1:0]      cfree_idx_reg, cfree_idx_next;
    logic [CIW-1:0]      k_idx_reg, k_idx_next;
    logic [CNT_W-1:0]    k_val_reg, k_val_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic [EXP_W-1:0]    out_exp_reg, out_exp_next;
    logic [CFG_W-1:0]    thr_reg, thr_next, wsec_reg, wsec_next, bsec_reg, bsec_next;

    // Stores.
    logic [ADDR_W-1:0]  ckey_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0]   cval_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  bkey_mem [BAN_ENTRIES];
    logic [STAMP_W-1:0] buntil_mem [BAN_ENTRIES];
    win_entry_t         win_mem [WINDOW_DEPTH];
    logic [TABLE_ENTRIES-1:0] cvalid_reg;
    logic [BAN_ENTRIES-1:0]   bvalid_reg;

    logic [ADDR_W-1:0]  ckey_rd_reg;
    logic [CNT_W-1:0]   cval_rd_reg;
    logic [ADDR_W-1:0]  bkey_rd_reg;
    logic [STAMP_W-1:0] buntil_rd_reg;
    win_entry_t         win_rd_reg;

    logic               cnt_we, cvalid_set, cvalid_clr;
    logic [CIW-1:0]     cnt_waddr;
    logic [ADDR_W-1:0]  cnt_wkey;
    logic [CNT_W-1:0]   cnt_wval;
    logic               ban_we;
    logic [BIW-1:0]     ban_waddr;
    logic               win_we;
    win_entry_t         win_wdata;

    alu_op_t  alu_op;
    alu_res_t alu_res;

    logic [PW:0]        win_used;
    logic               win_full;
    logic [WIW-1:0]     head_idx, tail_idx;
    logic [PW-1:0]      head_inc, tail_inc;
    logic [STAMP_W-1:0] until_eff;
    logic               ban_active, ban_hit;
    logic               c_vld, c_match, c_new_free;
    logic [ADDR_W-1:0]  cmp_addr;
    logic [CNT_W-1:0]   new_val;

    swsb_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign win_used = (head_reg >= tail_reg)
                    ? ({1'b0, head_reg} - {1'b0, tail_reg})
                    : ({1'b0, head_reg} + P_SPAN - {1'b0, tail_reg});
    assign win_full = (win_used >= P_FULL);
    assign head_idx = (head_reg >= P_DEPTH) ? WIW'(head_reg - P_DEPTH) : WIW'(head_reg);
    assign tail_idx = (tail_reg >= P_DEPTH) ? WIW'(tail_reg - P_DEPTH) : WIW'(tail_reg);
    assign head_inc = (head_reg == P_TOP) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == P_TOP) ? '0 : tail_reg + 1'b1;

    // An empty ban slot reads as ending at time zero.
    assign until_eff  = bvalid_reg[bidx_reg] ? buntil_rd_reg : '0;
    assign ban_active = !alu_res.ge;
    assign ban_hit    = ban_active && (bkey_rd_reg == addr_reg);

    assign cmp_addr   = (state_reg == S_EXP_CHK) ? win_rd_reg.addr : addr_reg;
    assign c_vld      = cvalid_reg[cidx_reg];
    assign c_match    = c_vld && (ckey_rd_reg == cmp_addr);
    assign c_new_free = !cfree_reg && !c_vld;
    assign new_val    = (k_val_reg == CNT_MAX) ? k_val_reg : k_val_reg + 1'b1;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign source_count = out_count_reg;
    assign expired      = out_exp_reg;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        stamp_next      = stamp_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        bidx_next       = bidx_reg;
        cidx_next       = cidx_reg;
        bfree_next      = bfree_reg;
        bfree_idx_next  = bfree_idx_reg;
        old_idx_next    = old_idx_reg;
        old_val_next    = old_val_reg;
        cfree_next      = cfree_reg;
        cfree_idx_next  = cfree_idx_reg;
        k_idx_next      = k_idx_reg;
        k_val_next      = k_val_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        exp_next        = exp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_exp_next    = out_exp_reg;
        thr_next        = thr_reg;
        wsec_next       = wsec_reg;
        bsec_next       = bsec_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = k_idx_reg;
        cnt_wkey   = addr_reg;
        cnt_wval   = new_val;
        cvalid_set = 1'b0;
        cvalid_clr = 1'b0;
        ban_we     = 1'b0;
        ban_waddr  = bfree_reg ? bfree_idx_reg : old_idx_reg;
        win_we     = 1'b0;
        win_wdata  = '{addr: addr_reg, stamp: stamp_reg, dropped: 1'b0};

        alu_op.a = cur_reg;
        alu_op.b = {{(STAMP_W-CFG_W){1'b0}}, bsec_reg};
        alu_op.c = '0;
        if (state_reg == S_BAN_CHK)
        begin
            alu_op.b = '0;
            alu_op.c = until_eff;
        end
        else if (state_reg == S_TICK_CHK)
        begin
            alu_op.a = win_rd_reg.stamp;
            alu_op.b = {{(STAMP_W-CFG_W){1'b0}}, wsec_reg};
            alu_op.c = cur_reg;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_next  = cfg_data;
                CFG_WINDOW:    wsec_next = cfg_data;
                CFG_BAN:       bsec_next = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next      = source_addr;
                    stamp_next     = stamp;
                    res_count_next = '0;
                    exp_next       = '0;
                    if (cmd == CMD_TICK)
                    begin
                        cur_next   = stamp;
                        state_next = S_TICK_RD;
                    end
                    else if (win_full)
                    begin
                        res_status_next = ST_WFULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        bidx_next  = '0;
                        bfree_next = 1'b0;
                        state_next = S_BAN_RD;
                    end
                end
            end
            S_BAN_RD:
                state_next = S_BAN_CHK;
            S_BAN_CHK:
            begin
                if (ban_hit)
                begin
                    win_we            = 1'b1;
                    win_wdata.dropped = 1'b1;
                    head_next         = head_inc;
                    res_status_next   = ST_DROPPED;
                    state_next        = S_DONE;
                end
                else
                begin
                    if (!bfree_reg && !ban_active)
                    begin
                        bfree_next     = 1'b1;
                        bfree_idx_next = bidx_reg;
                    end
                    // The oldest ban is the first one with the smallest end time.
                    if (bidx_reg == '0 || until_eff < old_val_reg)
                    begin
                        old_idx_next = bidx_reg;
                        old_val_next = until_eff;
                    end
                    if (bidx_reg == B_LAST)
                    begin
                        cidx_next  = '0;
                        cfree_next = 1'b0;
                        state_next = S_CNT_RD;
                    end
                    else
                    begin
                        bidx_next  = bidx_reg + 1'b1;
                        state_next = S_BAN_RD;
                    end
                end
            end
            S_CNT_RD:
                state_next = S_CNT_CHK;
            S_CNT_CHK:
            begin
                if (c_match)
                begin
                    k_idx_next = cidx_reg;
                    k_val_next = cval_rd_reg;
                    state_next = S_UPDATE;
                end
                else
                begin
                    if (c_new_free)
                    begin
                        cfree_next     = 1'b1;
                        cfree_idx_next = cidx_reg;
                    end
                    if (cidx_reg == C_LAST)
                    begin
                        if (cfree_reg || c_new_free)
                        begin
                            k_idx_next = cfree_reg ? cfree_idx_reg : cidx_reg;
                            k_val_next = '0;
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            res_status_next = ST_TFULL;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        cidx_next  = cidx_reg + 1'b1;
                        state_next = S_CNT_RD;
                    end
                end
            end
            S_UPDATE:
            begin
                cnt_we         = 1'b1;
                cvalid_set     = 1'b1;
                win_we         = 1'b1;
                head_next      = head_inc;
                res_count_next = new_val;
                if (new_val >= thr_reg)
                begin
                    res_status_next = ST_BANNED;
                    state_next      = S_BAN_WR;
                end
                else
                begin
                    res_status_next = ST_COUNTED;
                    state_next      = S_DONE;
                end
            end
            S_BAN_WR:
            begin
                ban_we     = 1'b1;
                state_next = S_DONE;
            end
            S_TICK_RD:
            begin
                if (win_used == '0)
                begin
                    res_status_next = ST_TICK;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_CHK:
            begin
                if (alu_res.ge)
                begin
                    res_status_next = ST_TICK;
                    state_next      = S_DONE;
                end
                else if (win_rd_reg.dropped)
                begin
                    tail_next  = tail_inc;
                    exp_next   = exp_reg + 1'b1;
                    state_next = S_TICK_RD;
                end
                else
                begin
                    cidx_next  = '0;
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
                state_next = S_EXP_CHK;
            S_EXP_CHK:
            begin
                if (c_match || cidx_reg == C_LAST)
                begin
                    if (c_match && cval_rd_reg != '0)
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = cidx_reg;
                        cnt_wkey   = ckey_rd_reg;
                        cnt_wval   = cval_rd_reg - 1'b1;
                        cvalid_clr = (cval_rd_reg == CNT_W'(1));
                    end
                    tail_next  = tail_inc;
                    exp_next   = exp_reg + 1'b1;
                    state_next = S_TICK_RD;
                end
                else
                begin
                    cidx_next  = cidx_reg + 1'b1;
                    state_next = S_EXP_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    out_exp_next    = exp_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= THRESHOLD_RST;
            wsec_reg       <= WINDOW_RST;
            bsec_reg       <= BAN_RST;
            bidx_reg       <= '0;
            cidx_reg       <= '0;
            bfree_reg      <= 1'b0;
            cfree_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
            thr_reg        <= thr_next;
            wsec_reg       <= wsec_next;
            bsec_reg       <= bsec_next;
            bidx_reg       <= bidx_next;
            cidx_reg       <= cidx_next;
            bfree_reg      <= bfree_next;
            cfree_reg      <= cfree_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        stamp_reg      <= stamp_next;
        bfree_idx_reg  <= bfree_idx_next;
        old_idx_reg    <= old_idx_next;
        old_val_reg    <= old_val_next;
        cfree_idx_reg  <= cfree_idx_next;
        k_idx_reg      <= k_idx_next;
        k_val_reg      <= k_val_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        exp_reg        <= exp_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_exp_reg    <= out_exp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
            bvalid_reg <= '0;
        end
        else
        begin
            if (cvalid_set)
            begin
                cvalid_reg[k_idx_reg] <= 1'b1;
            end
            if (cvalid_clr)
            begin
                cvalid_reg[cidx_reg] <= 1'b0;
            end
            if (ban_we)
            begin
                bvalid_reg[ban_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            ckey_mem[cnt_waddr] <= cnt_wkey;
            cval_mem[cnt_waddr] <= cnt_wval;
        end
        ckey_rd_reg <= ckey_mem[cidx_reg];
        cval_rd_reg <= cval_mem[cidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ban_we)
        begin
            bkey_mem[ban_waddr]   <= addr_reg;
            buntil_mem[ban_waddr] <= alu_res.sum_sat;
        end
        bkey_rd_reg   <= bkey_mem[bidx_reg];
        buntil_rd_reg <= buntil_mem[bidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[head_idx] <= win_wdata;
        end
        win_rd_reg <= win_mem[tail_idx];
    end

`ifndef NO_ASSERTIONS
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_used <= P_FULL)
        else $error("window occupancy exceeds its depth");

    a_expired_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_TICK |-> out_exp_reg == '0)
        else $error("expired count on a result that is not a tick");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_COUNTED || out_status_reg == ST_BANNED)
        |-> out_count_reg != '0)
        else $error("counted item reports a zero count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/swsb_alu.sv @@
// Shared saturating adder and magnitude comparator used by the sequencer.
`default_nettype none

module swsb_alu
    import swsb_pkg::*;
(
    input  alu_op_t  op,
    output alu_res_t res
);

    logic [STAMP_W:0] sum;

    // The sum keeps its carry so that a + b >= c is exact across the 32-bit range.
    assign sum = {1'b0, op.a} + {1'b0, op.b};
    assign res.sum_sat = sum[STAMP_W] ? {STAMP_W{1'b1}} : sum[STAMP_W-1:0];
    assign res.ge = (sum >= {1'b0, op.c});

endmodule

`default_nettype wire
